/* design/spsa_pkg.sv */
// Shared types and codes for the strided port slot allocator.
package spsa_pkg;
    localparam logic [1:0] OP_ALLOC_ANY  = 2'd0;
    localparam logic [1:0] OP_ALLOC_SPEC = 2'd1;
    localparam logic [1:0] OP_RELEASE    = 2'd2;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_INVALID  = 2'd1;
    localparam logic [1:0] ST_IN_USE   = 2'd2;
    localparam logic [1:0] ST_NONE     = 2'd3;

    localparam logic [1:0] REG_BASE  = 2'd0;
    localparam logic [1:0] REG_STEP  = 2'd1;
    localparam logic [1:0] REG_LIMIT = 2'd2;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [15:0] port_value;
    } t_in_beat;

    typedef struct packed {
        logic [15:0] granted_port;
        logic [1:0]  status;
    } t_out_beat;

    // Front-to-back command: classified request.
    typedef struct packed {
        logic [1:0]  opcode;
        logic [15:0] port_value;
        logic        on_grid;     // in range and on the stride
        logic [16:0] slot;        // quotient of offset by step
    } t_cmd;
endpackage

/* design/strided_port_slot_allocator_top.sv */
// Strided port slot allocator: one request per beat, one result per beat.
// Allocate specific and release pass the divider, a pick and the result register;
// allocate any adds a scan of all slots (one slot per cycle scan), pick, multiply and grant.
// The front takes a new beat only once its divide is done and handed on; the back serves one command at a time.
// Front and back run decoupled through a two-entry command queue.
// Sync active-low reset loads register defaults; back then clears every slot to free.
module strided_port_slot_allocator_top #(
    parameter int NUM_SLOTS = 256
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  spsa_pkg::t_in_beat  i_data,
    output logic                o_valid,
    input  logic                i_ready,
    output spsa_pkg::t_out_beat o_data,
    input  logic                i_cfg_we,
    input  logic [1:0]          i_cfg_index,
    input  logic [16:0]         i_cfg_data
);
    import spsa_pkg::*;

    logic [15:0] r_base;
    logic [15:0] r_step;
    logic [16:0] r_limit;
    logic [16:0] w_limit;
    logic        w_fq_valid, w_fq_ready, w_qb_valid, w_qb_ready;
    t_cmd        w_fq_cmd, w_qb_cmd;

    assign w_limit = (r_limit > 17'd65536) ? 17'd65536 : r_limit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base  <= 16'd0;
            r_step  <= 16'd1;
            r_limit <= 17'd65536;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_BASE:  r_base  <= i_cfg_data[15:0];
                REG_STEP:  r_step  <= i_cfg_data[15:0];
                REG_LIMIT: r_limit <= i_cfg_data;
                default: ;
            endcase
        end
    end

    spsa_front u_front (
        .i_clk, .i_rst_n, .i_valid, .o_ready, .i_data,
        .i_base(r_base), .i_step(r_step), .i_limit(w_limit),
        .o_cmd_valid(w_fq_valid), .i_cmd_ready(w_fq_ready), .o_cmd(w_fq_cmd)
    );

    spsa_queue u_queue (
        .i_clk, .i_rst_n,
        .i_valid(w_fq_valid), .o_ready(w_fq_ready), .i_data(w_fq_cmd),
        .o_valid(w_qb_valid), .i_ready(w_qb_ready), .o_data(w_qb_cmd)
    );

    spsa_back #(.NUM_SLOTS(NUM_SLOTS)) u_back (
        .i_clk, .i_rst_n,
        .i_cmd_valid(w_qb_valid), .o_cmd_ready(w_qb_ready), .i_cmd(w_qb_cmd),
        .i_base(r_base), .i_step(r_step), .i_limit(w_limit),
        .o_valid, .i_ready, .o_data
    );

    a_err_port_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_data.status != ST_OK) |-> o_data.granted_port == 16'd0)
        else $error("error result carries a port");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_data))
        else $error("result changed while stalled");
    a_cfg_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_limit <= 17'd65536)
        else $error("clamped limit out of range");
endmodule

/* design/spsa_front.sv */
// Front end: accepts beats, divides port offset by the step (one bit per cycle).
module spsa_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  spsa_pkg::t_in_beat i_data,
    input  logic [15:0]       i_base,
    input  logic [15:0]       i_step,
    input  logic [16:0]       i_limit,
    output logic              o_cmd_valid,
    input  logic              i_cmd_ready,
    output spsa_pkg::t_cmd    o_cmd
);
    import spsa_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_DIV  = 2'd1;
    localparam logic [1:0] S_OUT  = 2'd2;

    logic [1:0]  r_state;
    t_in_beat    r_in;
    logic [15:0] r_rem;
    logic [15:0] r_quo;
    logic [15:0] r_num;
    logic [4:0]  r_cnt;
    logic        r_range;
    logic [15:0] w_step;
    logic [16:0] w_trial;

    assign w_step  = (i_step == 16'd0) ? 16'd1 : i_step;
    assign w_trial = {r_rem, r_num[15]} - {1'b0, w_step};
    assign o_ready = (r_state == S_IDLE);
    assign o_cmd_valid = (r_state == S_OUT);
    assign o_cmd.opcode     = r_in.opcode;
    assign o_cmd.port_value = r_in.port_value;
    assign o_cmd.on_grid    = r_range && (r_rem == 16'd0);
    assign o_cmd.slot       = {1'b0, r_quo};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            case (r_state)
                S_IDLE: if (i_valid) begin
                    r_in    <= i_data;
                    r_range <= (i_data.port_value >= i_base) &&
                               ({1'b0, i_data.port_value} < i_limit);
                    r_num   <= i_data.port_value - i_base;
                    r_rem   <= 16'd0;
                    r_quo   <= 16'd0;
                    r_cnt   <= 5'd0;
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    if (!w_trial[16]) begin
                        r_rem <= w_trial[15:0];
                        r_quo <= {r_quo[14:0], 1'b1};
                    end else begin
                        r_rem <= {r_rem[14:0], r_num[15]};
                        r_quo <= {r_quo[14:0], 1'b0};
                    end
                    r_num <= {r_num[14:0], 1'b0};
                    r_cnt <= r_cnt + 5'd1;
                    if (r_cnt == 5'd15) r_state <= S_OUT;
                end
                S_OUT: if (i_cmd_ready) r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

/* design/spsa_queue.sv */
// Two-entry queue between front and back end.
module spsa_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  spsa_pkg::t_cmd i_data,
    output logic           o_valid,
    input  logic           i_ready,
    output spsa_pkg::t_cmd o_data
);
    import spsa_pkg::*;

    t_cmd       r_mem [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    logic       w_push;
    logic       w_pop;

    assign o_ready = (r_cnt != 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_data  = r_mem[r_rp];
    assign w_push  = i_valid && o_ready;
    assign w_pop   = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (w_push) r_mem[r_wp] <= i_data;
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) r_wp <= ~r_wp;
            if (w_pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, w_pop};
        end
    end
endmodule

/* design/spsa_back.sv */
// Back end: slot memory; scans for highest used and lowest free slot, and serves allocate specific and release.
module spsa_back #(
    parameter int NUM_SLOTS = 256
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cmd_valid,
    output logic                o_cmd_ready,
    input  spsa_pkg::t_cmd      i_cmd,
    input  logic [15:0]         i_base,
    input  logic [15:0]         i_step,
    input  logic [16:0]         i_limit,
    output logic                o_valid,
    input  logic                i_ready,
    output spsa_pkg::t_out_beat o_data
);
    import spsa_pkg::*;

    localparam int SW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam logic [16:0] LAST = 17'(NUM_SLOTS - 1);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SCAN  = 3'd1;
    localparam logic [2:0] S_PICK  = 3'd2;
    localparam logic [2:0] S_MUL   = 3'd3;
    localparam logic [2:0] S_OUT   = 3'd4;
    localparam logic [2:0] S_GRANT = 3'd5;
    localparam logic [2:0] S_CLR   = 3'd6;

    logic          r_used [NUM_SLOTS];
    logic          r_rd;
    logic [2:0]    r_state;
    t_cmd          r_cmd;
    logic [16:0]   r_idx;
    logic [16:0]   r_pidx;
    logic          r_pv;
    logic          r_any;
    logic [16:0]   r_high;
    logic          r_lfound;
    logic          r_lstop;
    logic [16:0]   r_low;
    logic [16:0]   r_sel;
    logic [32:0]   r_port;
    t_out_beat     r_out;
    logic [15:0]   w_step;
    logic [32:0]   w_scan_port;
    logic [32:0]   w_next_port;
    logic          w_scan_avail;
    logic          w_next_avail;
    logic          w_spec_ok;
    logic          w_rel_hit;
    logic          w_we;
    logic          w_wdata;
    logic [SW-1:0] w_waddr;
    logic [SW-1:0] w_raddr;
    t_out_beat     w_pick_out;
    logic          w_pick_mul;
    logic [16:0]   w_pick_sel;

    assign w_step       = (i_step == 16'd0) ? 16'd1 : i_step;
    // one multiply per cycle for the scan pointer and one for the fast path
    assign w_scan_port  = {17'd0, i_base} + r_pidx * w_step;
    assign w_next_port  = {17'd0, i_base} + (r_high + 17'd1) * w_step;
    assign w_scan_avail = w_scan_port < {16'd0, i_limit};
    // the slot above the highest used one is free by definition
    assign w_next_avail = (r_high < LAST) && (w_next_port < {16'd0, i_limit});
    assign w_spec_ok    = r_cmd.on_grid && (r_cmd.slot <= LAST) && !r_rd;
    assign w_rel_hit    = r_cmd.on_grid && (r_cmd.slot <= LAST);
    // idle reads the slot of the incoming command, ready for the pick cycle
    assign w_raddr      = (r_state == S_IDLE) ? i_cmd.slot[SW-1:0] : r_idx[SW-1:0];
    assign o_cmd_ready  = (r_state == S_IDLE);
    assign o_valid      = (r_state == S_OUT);
    assign o_data       = r_out;

    always_comb begin
        w_we    = 1'b0;
        w_wdata = 1'b0;
        w_waddr = r_cmd.slot[SW-1:0];
        case (r_state)
            S_CLR: begin
                w_we    = 1'b1;
                w_waddr = r_idx[SW-1:0];
            end
            S_PICK: begin
                if (r_cmd.opcode == OP_ALLOC_SPEC && w_spec_ok) begin
                    w_we    = 1'b1;
                    w_wdata = 1'b1;
                end else if (r_cmd.opcode == OP_RELEASE && w_rel_hit) begin
                    w_we    = 1'b1;
                end
            end
            S_GRANT: begin
                w_we    = 1'b1;
                w_wdata = 1'b1;
                w_waddr = r_sel[SW-1:0];
            end
            default: ;
        endcase
    end

    always_comb begin
        w_pick_out = '{granted_port: 16'd0, status: ST_INVALID};
        w_pick_mul = 1'b0;
        w_pick_sel = r_low;
        case (r_cmd.opcode)
            OP_ALLOC_ANY: begin
                if (r_any && w_next_avail) begin
                    w_pick_mul = 1'b1;
                    w_pick_sel = r_high + 17'd1;
                end else if (r_lfound) begin
                    w_pick_mul = 1'b1;
                end else begin
                    w_pick_out.status = ST_NONE;
                end
            end
            OP_ALLOC_SPEC: begin
                if (!r_cmd.on_grid) begin
                    w_pick_out.status = ST_INVALID;
                end else if (!w_spec_ok) begin
                    w_pick_out.status = ST_IN_USE;
                end else begin
                    w_pick_out = '{granted_port: r_cmd.port_value, status: ST_OK};
                end
            end
            OP_RELEASE: begin
                w_pick_out = '{granted_port: r_cmd.port_value, status: ST_OK};
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_we) r_used[w_waddr] <= w_wdata;
        r_rd <= r_used[w_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
            r_idx   <= 17'd0;
        end else begin
            case (r_state)
                S_CLR: begin
                    r_idx <= r_idx + 17'd1;
                    if (r_idx == LAST) r_state <= S_IDLE;
                end
                S_IDLE: if (i_cmd_valid) begin
                    r_cmd    <= i_cmd;
                    r_idx    <= 17'd0;
                    r_pv     <= 1'b0;
                    r_any    <= 1'b0;
                    r_high   <= 17'd0;
                    r_lfound <= 1'b0;
                    r_lstop  <= 1'b0;
                    r_state  <= (i_cmd.opcode == OP_ALLOC_ANY) ? S_SCAN : S_PICK;
                end
                S_SCAN: begin
                    // read data is registered and belongs to the previous address, kept in r_pidx
                    if (r_pv) begin
                        if (r_rd) begin
                            r_any  <= 1'b1;
                            r_high <= r_pidx;
                        end
                        if (!r_lfound && !r_lstop) begin
                            if (!w_scan_avail) r_lstop <= 1'b1;
                            else if (!r_rd) begin
                                r_lfound <= 1'b1;
                                r_low    <= r_pidx;
                            end
                        end
                    end
                    r_pidx <= r_idx;
                    r_pv   <= 1'b1;
                    r_idx  <= r_idx + 17'd1;
                    if (r_pv && r_pidx == LAST) r_state <= S_PICK;
                end
                S_PICK: begin
                    r_out   <= w_pick_out;
                    r_sel   <= w_pick_sel;
                    r_state <= w_pick_mul ? S_MUL : S_OUT;
                end
                S_MUL: r_state <= S_GRANT;
                S_GRANT: begin
                    r_out   <= '{granted_port: r_port[15:0], status: ST_OK};
                    r_state <= S_OUT;
                end
                S_OUT: if (i_ready) r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_port <= {17'd0, i_base} + r_sel * w_step;
    end
endmodule
